// ===== hdl/met_pkg.sv =====
// Shared constants and types for the Mandelbrot escape-time unit.
// No dependencies; imported by mandelbrot_escape_time_unit.
package met_pkg;

  // Width of one input coordinate (signed fixed point)
  localparam int unsigned IN_BITS = 31;

  // Default fraction bits and count width
  localparam int unsigned FRAC_BITS_DEF  = 28;
  localparam int unsigned COUNT_BITS_DEF = 10;

  // Grey level width and full-scale value
  localparam int unsigned INT_BITS = 8;
  localparam logic [INT_BITS-1:0] INT_FULL = 8'd255;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITERS   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHECK_ITERS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NORM_MODE   = 2'd2;

  // Configuration reset values
  localparam int unsigned MAX_ITERS_RST   = 100;
  localparam int unsigned CHECK_ITERS_RST = 100;
  localparam logic        NORM_MODE_RST   = 1'b1;

  // Sequencer states
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_ADD   = 8'b0000_0010,
    ST_SQ_RE = 8'b0000_0100,
    ST_SQ_IM = 8'b0000_1000,
    ST_CHECK = 8'b0001_0000,
    ST_FIN   = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

endpackage

// ===== hdl/mandelbrot_escape_time_unit.sv =====
// Mandelbrot escape-time unit: iterates z = z*z + c on one shared multiplier.
// Depends on met_pkg for constants and the sequencer state type.
//
// One item is a point c; the unit returns its escape step count, a grey
// intensity and a paint flag. All arithmetic runs through a single signed
// multiplier of FRAC_BITS+3 bits a side. Each iteration steps through add,
// square real, square imaginary, and compare while forming the next x*y.
// The grey level comes from an 8-step restoring divider.
// A finished result sits in an output register, so the next item is taken
// while it waits. Configuration writes are taken only when the unit is idle
// with no result pending.
module mandelbrot_escape_time_unit
  import met_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [IN_BITS-1:0]    c_re_i,
  input  logic signed [IN_BITS-1:0]    c_im_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [COUNT_BITS-1:0]        escape_count_o,
  output logic [INT_BITS-1:0]          intensity_o,
  output logic                         paint_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [COUNT_BITS-1:0]        cfg_data_i
);

  // z holds values up to +/-2, squares up to 4, x*y term up to +/-8
  localparam int unsigned ZW   = FRAC_BITS + 3;
  localparam int unsigned PW   = 2 * ZW;
  localparam int unsigned SQW  = FRAC_BITS + 3;
  localparam int unsigned SUMW = FRAC_BITS + 4;
  localparam int unsigned XYW  = FRAC_BITS + 5;
  localparam int unsigned SW   = ((XYW > IN_BITS) ? XYW : IN_BITS) + 2;
  localparam int unsigned DW   = COUNT_BITS + INT_BITS;
  localparam int unsigned DCW  = $clog2(INT_BITS);

  localparam logic signed [SW-1:0] TWO_FX =
    {{(SW-FRAC_BITS-2){1'b0}}, 2'b10, {FRAC_BITS{1'b0}}};
  localparam logic signed [SW-1:0] NEG_TWO_FX = -TWO_FX;
  localparam logic [SUMW-1:0] FOUR_FX = {2'b01, {(FRAC_BITS+2){1'b0}}};

  // Control state
  state_e                  state_q, state_d;
  logic [COUNT_BITS-1:0]   i_q, i_d;
  logic [DCW-1:0]          div_cnt_q, div_cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [COUNT_BITS-1:0]   max_iters_q, check_iters_q;
  logic                    norm_mode_q;

  // Datapath registers
  logic signed [IN_BITS-1:0] cr_q, cr_d, ci_q, ci_d;
  logic signed [ZW-1:0]      x_q, x_d, y_q, y_d;
  logic [SQW-1:0]            xx_q, xx_d, yy_q, yy_d;
  logic signed [PW-1:0]      p_q, p_d;
  logic [COUNT_BITS-1:0]     count_q, count_d;
  logic [COUNT_BITS-1:0]     rem_q, rem_d;
  logic [INT_BITS-1:0]       lo_q, lo_d, quo_q, quo_d;
  logic                      use_special_q, use_special_d;
  logic [INT_BITS-1:0]       special_q, special_d;
  logic [COUNT_BITS-1:0]     escape_count_q, escape_count_d;
  logic [INT_BITS-1:0]       intensity_q, intensity_d;
  logic                      paint_q, paint_d;

  // Combinational datapath
  logic signed [ZW-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    mul_p;
  logic [SQW-1:0]          sq_fl;
  logic signed [XYW-1:0]   xy_fl;
  logic signed [SW-1:0]    nr, ni;
  logic                    out_of_range;
  logic [SUMW-1:0]         mag_sum;
  logic                    escaped;
  logic [COUNT_BITS-1:0]   i_next;
  logic [COUNT_BITS-1:0]   clip, norm;
  logic [DW-1:0]           prod255;
  logic [COUNT_BITS:0]     div_try;
  logic                    div_ge;
  logic                    in_take, out_take, out_free;

  assign in_take  = in_valid_i && (state_q == ST_IDLE);
  assign out_take = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // Shared multiplier: x*y, x*x or y*y depending on the step
  assign mul_a = (state_q == ST_SQ_IM) ? y_q : x_q;
  assign mul_b = (state_q == ST_SQ_RE) ? x_q : y_q;
  assign mul_p = mul_a * mul_b;

  // Floored products: squares by 2^F, the cross term doubled
  assign sq_fl = p_q[FRAC_BITS +: SQW];
  assign xy_fl = p_q[FRAC_BITS-1 +: XYW];

  // New z and escape tests
  assign nr = SW'($signed({1'b0, xx_q})) - SW'($signed({1'b0, yy_q})) + SW'(cr_q);
  assign ni = SW'(xy_fl) + SW'(ci_q);
  assign out_of_range = (nr > TWO_FX) || (nr < NEG_TWO_FX) ||
                        (ni > TWO_FX) || (ni < NEG_TWO_FX);
  assign mag_sum = SUMW'(xx_q) + SUMW'(sq_fl);
  assign escaped = mag_sum > FOUR_FX;
  assign i_next  = i_q + COUNT_BITS'(1);

  // Grey level operands
  assign clip    = (count_q < check_iters_q) ? count_q : check_iters_q;
  assign norm    = norm_mode_q ? max_iters_q : check_iters_q;
  assign prod255 = {clip, {INT_BITS{1'b0}}} - DW'(clip);

  // Restoring divider step
  assign div_try = {rem_q, lo_q[INT_BITS-1]};
  assign div_ge  = div_try >= {1'b0, norm};

  // Sequencer
  always_comb begin
    state_d        = state_q;
    i_d            = i_q;
    div_cnt_d      = div_cnt_q;
    out_valid_d    = out_valid_q && !out_take;
    cr_d           = cr_q;
    ci_d           = ci_q;
    x_d            = x_q;
    y_d            = y_q;
    xx_d           = xx_q;
    yy_d           = yy_q;
    p_d            = p_q;
    count_d        = count_q;
    rem_d          = rem_q;
    lo_d           = lo_q;
    quo_d          = quo_q;
    use_special_d  = use_special_q;
    special_d      = special_q;
    escape_count_d = escape_count_q;
    intensity_d    = intensity_q;
    paint_d        = paint_q;
    case (state_q)
      ST_IDLE: begin
        // take a point, start from z = 0
        if (in_take) begin
          cr_d    = c_re_i;
          ci_d    = c_im_i;
          x_d     = '0;
          y_d     = '0;
          xx_d    = '0;
          yy_d    = '0;
          p_d     = '0;
          i_d     = '0;
          count_d = '0;
          state_d = (max_iters_q == '0) ? ST_FIN : ST_ADD;
        end
      end
      ST_ADD: begin
        // form new z; drop out if a component is beyond two
        if (out_of_range) begin
          count_d = i_q;
          state_d = ST_FIN;
        end else begin
          x_d     = nr[ZW-1:0];
          y_d     = ni[ZW-1:0];
          state_d = ST_SQ_RE;
        end
      end
      ST_SQ_RE: begin
        p_d     = mul_p;
        state_d = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        xx_d    = sq_fl;
        p_d     = mul_p;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // magnitude test; start next cross product meanwhile
        yy_d = sq_fl;
        p_d  = mul_p;
        if (escaped) begin
          count_d = i_q;
          state_d = ST_FIN;
        end else if (i_next == max_iters_q) begin
          count_d = max_iters_q;
          state_d = ST_FIN;
        end else begin
          i_d     = i_next;
          state_d = ST_ADD;
        end
      end
      ST_FIN: begin
        // set up the divider and the saturated or zero cases
        use_special_d = (norm == '0) || (clip >= norm);
        special_d     = (norm == '0) ? '0 : INT_FULL;
        rem_d         = prod255[DW-1:INT_BITS];
        lo_d          = prod255[INT_BITS-1:0];
        quo_d         = '0;
        div_cnt_d     = '0;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        // one quotient bit per cycle
        rem_d     = div_ge ? COUNT_BITS'(div_try - {1'b0, norm})
                           : div_try[COUNT_BITS-1:0];
        lo_d      = {lo_q[INT_BITS-2:0], 1'b0};
        quo_d     = {quo_q[INT_BITS-2:0], div_ge};
        div_cnt_d = div_cnt_q + DCW'(1);
        if (div_cnt_q == DCW'(INT_BITS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hand the result to the output register once it is free
        if (out_free) begin
          out_valid_d    = 1'b1;
          escape_count_d = count_q;
          intensity_d    = use_special_q ? special_q : quo_q;
          paint_d        = clip != '0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iters_q   <= COUNT_BITS'(MAX_ITERS_RST);
      check_iters_q <= COUNT_BITS'(CHECK_ITERS_RST);
      norm_mode_q   <= NORM_MODE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MAX_ITERS:   max_iters_q   <= cfg_data_i;
        CFG_CHECK_ITERS: check_iters_q <= cfg_data_i;
        CFG_NORM_MODE:   norm_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cr_q           <= cr_d;
    ci_q           <= ci_d;
    x_q            <= x_d;
    y_q            <= y_d;
    xx_q           <= xx_d;
    yy_q           <= yy_d;
    p_q            <= p_d;
    count_q        <= count_d;
    rem_q          <= rem_d;
    lo_q           <= lo_d;
    quo_q          <= quo_d;
    use_special_q  <= use_special_d;
    special_q      <= special_d;
    escape_count_q <= escape_count_d;
    intensity_q    <= intensity_d;
    paint_q        <= paint_d;
  end

  assign in_stall_o     = state_q != ST_IDLE;
  assign cfg_ready_o    = (state_q == ST_IDLE) && !out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign escape_count_o = escape_count_q;
  assign intensity_o    = intensity_q;
  assign paint_o        = paint_q;

`ifndef SYNTHESIS
  // An accepted item always starts the sequencer
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("accepted item did not start the sequencer");

  // The step counter stays below the limit while iterating
  a_step_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD || state_q == ST_SQ_RE || state_q == ST_SQ_IM ||
     state_q == ST_CHECK) |-> (i_q < max_iters_q))
    else $error("iteration counter reached the limit");

  // z components entering the squarer stay within two in magnitude
  a_z_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ_RE) |->
      ((SW'(x_q) <= TWO_FX) && (SW'(x_q) >= NEG_TWO_FX) &&
       (SW'(y_q) <= TWO_FX) && (SW'(y_q) >= NEG_TWO_FX)))
    else $error("z component beyond range entered the squarer");

  // A divided grey level is below full scale
  a_quotient_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !use_special_q) |-> (quo_q != INT_FULL))
    else $error("divider quotient reached full scale");

  // An unpainted pixel has zero intensity
  a_unpainted_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !paint_o) |-> (intensity_o == '0))
    else $error("unpainted result with nonzero intensity");
`endif

endmodule
